@@ sv/slop_pkg.sv @@
// Shared types and constants for the sorted list with odd purge.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package slop_pkg;

   localparam int CAPACITY = 16;
   localparam int LIMIT    = (CAPACITY < 16) ? CAPACITY : 16;
   localparam int IDX_W    = $clog2(LIMIT);
   localparam int CNT_W    = $clog2(LIMIT + 1);

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_PURGE  = 2'd1;
   localparam logic [1:0] MODE_DUMP   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_PUT,
      ST_PRG_RD,
      ST_PRG_WR,
      ST_DMP_RD,
      ST_DMP_OUT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [31:0]       wdata;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

   typedef struct packed {
      logic ge;
      logic pos_odd;
   } cmp_res_type;

endpackage

@@ sv/slop_store.sv @@
// Value store: one write port and one registered read port.
// Depends on slop_pkg.
`timescale 1ns / 1ps

module slop_store (
   input  logic                 clock,
   input  slop_pkg::mem_req_type mem_req,
   output logic [31:0]          rd_data
);
   import slop_pkg::*;

   logic [31:0] mem_ff [LIMIT];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem_ff[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/slop_cmp.sv @@
// Shared compare unit: signed greater-or-equal and positive-odd test.
// Depends on slop_pkg.
`timescale 1ns / 1ps

module slop_cmp (
   input  logic signed [31:0]    a,
   input  logic signed [31:0]    b,
   output slop_pkg::cmp_res_type res
);
   import slop_pkg::*;

   always_comb begin
      res.ge      = (a >= b);
      res.pos_odd = !a[31] && a[0];
   end

endmodule

@@ sv/slop_ctrl.sv @@
// Sequencer for insert, purge and dump, plus the result register.
// Depends on slop_pkg; drives slop_store and uses slop_cmp results.
`timescale 1ns / 1ps

module slop_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic signed [31:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_element,
   output logic [3:0]            rsp_position,
   output logic [4:0]            rsp_length,
   output logic [4:0]            rsp_removed,
   output logic                  rsp_dropped,
   output logic                  rsp_empty_dump,
   output logic                  rsp_is_last,
   output slop_pkg::mem_req_type mem_req,
   input  logic signed [31:0]    rd_data,
   output logic signed [31:0]    cmp_b,
   input  slop_pkg::cmp_res_type cmp_res
);
   import slop_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic signed [31:0] value_ff, value_in;
   logic dropped_ff, dropped_in;
   logic empty_ff, empty_in;
   logic purge_ff, purge_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_element_ff, rsp_element_in;
   logic [3:0]         rsp_position_ff, rsp_position_in;
   logic [4:0]         rsp_length_ff, rsp_length_in;
   logic [4:0]         rsp_removed_ff, rsp_removed_in;
   logic               rsp_dropped_ff, rsp_dropped_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_last_ff, rsp_last_in;

   logic accept;
   logic out_free;
   logic load;
   logic walk_last;
   logic [CNT_W-1:0] purge_removed;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign walk_last = ((CNT_W'(idx_ff) + 1'b1) == n_ff);
   assign purge_removed = n_ff - kept_ff;
   assign cmp_b     = value_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_INSERT: begin
                     if (count_ff == CNT_W'(LIMIT)) begin
                        state_in = ST_RESP;
                     end else if (count_ff == '0) begin
                        state_in = ST_INS_PUT;
                     end else begin
                        state_in = ST_INS_RD;
                     end
                  end
                  MODE_PURGE: begin
                     state_in = (count_ff == '0) ? ST_RESP : ST_PRG_RD;
                  end
                  MODE_DUMP: begin
                     state_in = (count_ff == '0) ? ST_RESP : ST_DMP_RD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_RD:  state_in = ST_INS_WR;
         ST_INS_WR: begin
            if (!cmp_res.ge) begin
               state_in = ST_RESP;
            end else if (idx_ff == '0) begin
               state_in = ST_INS_PUT;
            end else begin
               state_in = ST_INS_RD;
            end
         end
         ST_INS_PUT: state_in = ST_RESP;
         ST_PRG_RD:  state_in = ST_PRG_WR;
         ST_PRG_WR:  state_in = walk_last ? ST_RESP : ST_PRG_RD;
         ST_DMP_RD:  state_in = ST_DMP_OUT;
         ST_DMP_OUT: begin
            if (out_free) begin
               state_in = walk_last ? ST_IDLE : ST_DMP_RD;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in   = count_ff;
      n_in       = n_ff;
      kept_in    = kept_ff;
      idx_in     = idx_ff;
      value_in   = value_ff;
      dropped_in = dropped_ff;
      empty_in   = empty_ff;
      purge_in   = purge_ff;

      mem_req.we    = 1'b0;
      mem_req.waddr = idx_ff + 1'b1;
      mem_req.wdata = rd_data;
      mem_req.raddr = idx_ff;

      load            = 1'b0;
      rsp_element_in  = rsp_element_ff;
      rsp_position_in = rsp_position_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_removed_in  = rsp_removed_ff;
      rsp_dropped_in  = rsp_dropped_ff;
      rsp_empty_in    = rsp_empty_ff;
      rsp_last_in     = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in   = req_value;
               dropped_in = 1'b0;
               empty_in   = 1'b0;
               purge_in   = 1'b0;
               n_in       = count_ff;
               kept_in    = '0;
               idx_in     = '0;
               case (req_mode)
                  MODE_INSERT: begin
                     if (count_ff == CNT_W'(LIMIT)) begin
                        dropped_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                        if (count_ff != '0) begin
                           idx_in = IDX_W'(count_ff - 1'b1);
                        end
                     end
                  end
                  MODE_PURGE: purge_in = 1'b1;
                  MODE_DUMP:  empty_in = (count_ff == '0);
                  default: ;
               endcase
            end
         end
         ST_INS_WR: begin
            mem_req.we = 1'b1;
            if (cmp_res.ge) begin
               mem_req.wdata = rd_data;
               if (idx_ff != '0) begin
                  idx_in = idx_ff - 1'b1;
               end
            end else begin
               mem_req.wdata = value_ff;
            end
         end
         ST_INS_PUT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = value_ff;
         end
         ST_PRG_WR: begin
            mem_req.waddr = IDX_W'(kept_ff);
            mem_req.wdata = rd_data;
            if (!cmp_res.pos_odd) begin
               mem_req.we = 1'b1;
               kept_in    = kept_ff + 1'b1;
            end
            if (walk_last) begin
               count_in = kept_in;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DMP_OUT: begin
            if (out_free) begin
               load            = 1'b1;
               rsp_element_in  = rd_data;
               rsp_position_in = 4'(idx_ff);
               rsp_length_in   = 5'(n_ff);
               rsp_removed_in  = '0;
               rsp_dropped_in  = 1'b0;
               rsp_empty_in    = 1'b0;
               rsp_last_in     = walk_last;
               if (!walk_last) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               load            = 1'b1;
               rsp_element_in  = '0;
               rsp_position_in = '0;
               rsp_length_in   = 5'(count_ff);
               rsp_removed_in  = purge_ff ? 5'(purge_removed) : 5'd0;
               rsp_dropped_in  = dropped_ff;
               rsp_empty_in    = empty_ff;
               rsp_last_in     = 1'b1;
            end
         end
         default: ;
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      kept_ff         <= kept_in;
      idx_ff          <= idx_in;
      value_ff        <= value_in;
      dropped_ff      <= dropped_in;
      empty_ff        <= empty_in;
      purge_ff        <= purge_in;
      rsp_element_ff  <= rsp_element_in;
      rsp_position_ff <= rsp_position_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_removed_ff  <= rsp_removed_in;
      rsp_dropped_ff  <= rsp_dropped_in;
      rsp_empty_ff    <= rsp_empty_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_element    = rsp_element_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_removed    = rsp_removed_ff;
   assign rsp_dropped    = rsp_dropped_ff;
   assign rsp_empty_dump = rsp_empty_ff;
   assign rsp_is_last    = rsp_last_ff;

endmodule

@@ sv/sorted_list_with_odd_purge.sv @@
// Top level of the sorted list with odd purge: sequencer, compare unit, store.
// Depends on slop_pkg, slop_store, slop_cmp, slop_ctrl.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_mode, req_value
//   rsp     | out       | rsp_valid / rsp_ready | element, position, length,
//           |           |                       | removed, dropped, empty_dump, is_last
//
// Steps per item, from the req transfer to ready again: Insert reads and writes each
// entry compared, with a put state when the value lands at the front, then responds
// (empty store: put, response; full store: response only). Purge reads and writes
// each stored entry, then responds. Dump reads and emits each entry (empty: responds).
// Each walk step pays the registered read of the store's single read port.
// Synchronous reset empties the list; store contents are not cleared.
// A stalled rsp holds the sequencer; req_ready is low until the item ends.
`timescale 1ns / 1ps

module sorted_list_with_odd_purge (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_element,
   output logic [3:0]         rsp_position,
   output logic [4:0]         rsp_length,
   output logic [4:0]         rsp_removed,
   output logic               rsp_dropped,
   output logic               rsp_empty_dump,
   output logic               rsp_is_last
);
   import slop_pkg::*;

   mem_req_type        mem_req;
   logic signed [31:0] rd_data;
   logic signed [31:0] cmp_b;
   cmp_res_type        cmp_res;

   slop_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   slop_cmp u_cmp (
      .a   (rd_data),
      .b   (cmp_b),
      .res (cmp_res)
   );

   slop_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_element    (rsp_element),
      .rsp_position   (rsp_position),
      .rsp_length     (rsp_length),
      .rsp_removed    (rsp_removed),
      .rsp_dropped    (rsp_dropped),
      .rsp_empty_dump (rsp_empty_dump),
      .rsp_is_last    (rsp_is_last),
      .mem_req        (mem_req),
      .rd_data        (rd_data),
      .cmp_b          (cmp_b),
      .cmp_res        (cmp_res)
   );

endmodule

@@ sv/slop_check.sv @@
// Port-level checks for the sorted list with odd purge, bound to the top.
// Depends on slop_pkg and sorted_list_with_odd_purge.
`timescale 1ns / 1ps

module slop_check (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_element,
   input logic [3:0]         rsp_position,
   input logic [4:0]         rsp_length,
   input logic [4:0]         rsp_removed,
   input logic               rsp_dropped,
   input logic               rsp_empty_dump,
   input logic               rsp_is_last
);
   import slop_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element) && $stable(rsp_is_last))
      else $error("rsp changed while stalled");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_is_last && (rsp_length == 5'(LIMIT)))
      else $error("drop without full list");

   a_empty_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_dump |-> rsp_is_last && (rsp_length == 5'd0)
                                      && (rsp_element == 32'sd0))
      else $error("bad empty dump result");

   a_mid_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> (rsp_removed == 5'd0) && !rsp_dropped
                                    && !rsp_empty_dump && (rsp_position < rsp_length))
      else $error("bad intermediate dump result");

   a_purge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_removed != 5'd0) |-> rsp_is_last && (rsp_position == 4'd0)
                                             && !rsp_dropped && !rsp_empty_dump)
      else $error("bad purge result");

endmodule

bind sorted_list_with_odd_purge slop_check u_slop_check (.*);

@@ verif/tb_sorted_list_with_odd_purge.sv @@
// Testbench for sorted_list_with_odd_purge: queue-fed driver, clocked monitor, list predictor.
// A directed pass is followed by random insert, purge and dump traffic with random stalls.
// Depends on slop_pkg and the sorted_list_with_odd_purge RTL.
`timescale 1ns / 1ps

module tb_sorted_list_with_odd_purge;
   import slop_pkg::*;

   localparam logic [1:0] MODE_NONE   = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         DRAIN_WAIT  = 64;
   localparam int         RAND_ITEMS  = 500;

   typedef struct {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } list_req_type;

   typedef struct {
      logic signed [31:0] element;
      logic [3:0]         position;
      logic [4:0]         length;
      logic [4:0]         removed;
      logic               dropped;
      logic               empty_dump;
      logic               is_last;
   } list_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_INSERT;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_element;
   logic [3:0]         rsp_position;
   logic [4:0]         rsp_length;
   logic [4:0]         rsp_removed;
   logic               rsp_dropped;
   logic               rsp_empty_dump;
   logic               rsp_is_last;

   list_req_type       pending_req[$];
   list_rsp_type       expected_rsp[$];
   logic signed [31:0] list_vals[LIMIT];
   int                 list_len = 0;
   logic               req_taken = 1'b0;
   int                 cycle_count = 0;
   int                 mismatch_count = 0;

   sorted_list_with_odd_purge uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_element    (rsp_element),
      .rsp_position   (rsp_position),
      .rsp_length     (rsp_length),
      .rsp_removed    (rsp_removed),
      .rsp_dropped    (rsp_dropped),
      .rsp_empty_dump (rsp_empty_dump),
      .rsp_is_last    (rsp_is_last)
   );

   always #6 clock = ~clock;

   function automatic int idle_pct();
      // quiet window with no idling on either side
      if (cycle_count >= 2500 && cycle_count < 5000) return 0;
      return 31;
   endfunction

   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 25) return $urandom;
      if (sel < 50) return $signed($urandom_range(16)) - 8;
      if (sel < 65) begin
         case ($urandom_range(6))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0001;
            3: return 32'sh7fff_fffe;
            4: return 0;
            5: return -1;
            default: return 1;
         endcase
      end
      if ($urandom_range(1)) return $signed($urandom_range(1000));
      return -$signed($urandom_range(1000));
   endfunction

   task automatic push_req(input logic [1:0] mode, input logic signed [31:0] value);
      list_req_type it;
      it.mode  = mode;
      it.value = value;
      pending_req.push_back(it);
   endtask

   task automatic predict_list_op(input logic [1:0] mode, input logic signed [31:0] value);
      list_rsp_type r;
      int at;
      int kept;
      int n;
      logic signed [31:0] v;
      r = '{element: '0, position: '0, length: '0, removed: '0,
            dropped: 1'b0, empty_dump: 1'b0, is_last: 1'b1};
      n = list_len;
      case (mode)
         MODE_INSERT: begin
            if (n >= LIMIT) begin
               r.dropped = 1'b1;
            end else begin
               at = 0;
               while (at < n && list_vals[at] < value) at++;
               for (int i = n; i > at; i--) list_vals[i] = list_vals[i-1];
               list_vals[at] = value;
               n++;
            end
            list_len = n;
            r.length = n[4:0];
            expected_rsp.push_back(r);
         end
         MODE_PURGE: begin
            kept = 0;
            for (int i = 0; i < n; i++) begin
               v = list_vals[i];
               if (v[31] || !v[0]) begin
                  list_vals[kept] = v;
                  kept++;
               end
            end
            list_len  = kept;
            r.length  = kept[4:0];
            r.removed = 5'(n - kept);
            expected_rsp.push_back(r);
         end
         MODE_DUMP: begin
            if (n == 0) begin
               r.empty_dump = 1'b1;
               expected_rsp.push_back(r);
            end else begin
               for (int i = 0; i < n; i++) begin
                  r.element  = list_vals[i];
                  r.position = i[3:0];
                  r.length   = n[4:0];
                  r.is_last  = (i == n - 1);
                  expected_rsp.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   // driver: a valid item is held until its transfer
   always @(negedge clock) begin
      list_req_type it;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct());
         if (req_valid && !req_taken) begin
            // hold
         end else if (pending_req.size() > 0 && $urandom_range(99) >= idle_pct()) begin
            it = pending_req.pop_front();
            req_valid <= 1'b1;
            req_mode  <= it.mode;
            req_value <= it.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type exp_r;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            got = '{element: rsp_element, position: rsp_position, length: rsp_length,
                    removed: rsp_removed, dropped: rsp_dropped,
                    empty_dump: rsp_empty_dump, is_last: rsp_is_last};
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"unexpected rsp transfer: elem=%0d pos=%0d len=%0d rem=%0d",
                            " drop=%0b empty=%0b last=%0b"},
                           got.element, got.position, got.length, got.removed,
                           got.dropped, got.empty_dump, got.is_last);
            end else begin
               exp_r = expected_rsp.pop_front();
               if (got.element !== exp_r.element || got.position !== exp_r.position ||
                   got.length !== exp_r.length || got.removed !== exp_r.removed ||
                   got.dropped !== exp_r.dropped || got.empty_dump !== exp_r.empty_dump ||
                   got.is_last !== exp_r.is_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"mismatch exp: elem=%0d pos=%0d len=%0d rem=%0d",
                               " drop=%0b empty=%0b last=%0b"},
                              exp_r.element, exp_r.position, exp_r.length, exp_r.removed,
                              exp_r.dropped, exp_r.empty_dump, exp_r.is_last);
                     $display({"         got: elem=%0d pos=%0d len=%0d rem=%0d",
                               " drop=%0b empty=%0b last=%0b"},
                              got.element, got.position, got.length, got.removed,
                              got.dropped, got.empty_dump, got.is_last);
                  end
               end
            end
         end
         if (req_valid && req_ready) predict_list_op(req_mode, req_value);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int gen;
      int pick;
      int burst;

      // directed: empty cases, extremes, duplicates, negative odd, full store
      push_req(MODE_DUMP, 32'sh7fff_ffff);
      push_req(MODE_PURGE, 32'sh8000_0000);
      push_req(MODE_INSERT, 32'sh7fff_ffff);
      push_req(MODE_INSERT, 32'sh8000_0000);
      push_req(MODE_INSERT, 0);
      push_req(MODE_INSERT, -1);
      push_req(MODE_INSERT, 1);
      push_req(MODE_INSERT, 1);
      push_req(MODE_INSERT, -3);
      push_req(MODE_DUMP, 0);
      push_req(MODE_PURGE, -1);
      push_req(MODE_DUMP, -1);
      push_req(MODE_NONE, 32'sh5a5a_a5a5);
      for (int i = 0; i < 12; i++) push_req(MODE_INSERT, 111 - i);
      push_req(MODE_INSERT, 32'sh8000_0000);
      push_req(MODE_DUMP, 0);
      push_req(MODE_PURGE, 0);
      push_req(MODE_DUMP, 0);

      gen = 0;
      while (gen < RAND_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            burst = $urandom_range(20, 12);
            repeat (burst) push_req(MODE_INSERT, pick_value());
            gen += burst;
         end else if (pick < 60) begin
            push_req(MODE_INSERT, pick_value());
            gen++;
         end else if (pick < 75) begin
            push_req(MODE_PURGE, $urandom);
            gen++;
         end else if (pick < 94) begin
            push_req(MODE_DUMP, $urandom);
            gen++;
         end else begin
            push_req(MODE_NONE, $urandom);
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_valid) @(negedge clock);
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/slop_pkg.sv
sv/slop_store.sv
sv/slop_cmp.sv
sv/slop_ctrl.sv
sv/sorted_list_with_odd_purge.sv
sv/slop_check.sv
verif/tb_sorted_list_with_odd_purge.sv
